>>> rtl/kbcf_pkg.sv
// Package for the keystroke burst code framer: sizes, register indexes,
// item, configuration, queue and write structs, and state enums.
// No dependencies; every rtl file but kbcf_ram refers to it by scoped names.
`default_nettype none

package kbcf_pkg;

  localparam int MAX_CODE_LEN = 64;
  localparam int IDX_W        = $clog2(MAX_CODE_LEN);
  localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
  localparam int MIN_W        = 7;
  localparam int CMP_W        = (LEN_W > MIN_W) ? LEN_W : MIN_W;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_HOLD     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTINGS_LOCKED = 2'd3;

  localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;
  localparam logic [6:0]  MIN_LENGTH_RST  = 7'd6;
  localparam logic [15:0] REPEAT_HOLD_RST = 16'd2000;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  localparam logic STATUS_ACCEPT = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic        has_char;
    logic [7:0]  char_code;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_char;
    logic       code_last;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] gap_timeout;
    logic [6:0]  min_code_length;
    logic [15:0] repeat_hold;
    logic        settings_locked;
  } cfg_t;

  typedef struct packed {
    logic             reject;
    logic             bank;
    logic [LEN_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_WAIT,
    F_CMP
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_RUN
  } back_state_t;

endpackage

`default_nettype wire

>>> rtl/kbcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kbcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/kbcf_front.sv
// Front end: accepts events, tracks the open burst and the previous code,
// compares a closed burst with the previous code, and queues run commands.
// Depends on kbcf_pkg.
`default_nettype none

module kbcf_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kbcf_pkg::cfg_t             cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire kbcf_pkg::in_item_t         in_data,
  output kbcf_pkg::wr_t                   wr,
  output logic [kbcf_pkg::IDX_W-1:0]      cmp_addr,
  input  wire logic [7:0]                 rdata0,
  input  wire logic [7:0]                 rdata1,
  input  wire logic                       back_idle,
  output logic                            cmd_push,
  output kbcf_pkg::cmd_t                  cmd
);

  kbcf_pkg::front_state_t state_r, state_nxt;

  logic [kbcf_pkg::LEN_W-1:0] blen_r, blen_nxt;
  logic [31:0]                lct_r, lct_nxt;
  logic [kbcf_pkg::LEN_W-1:0] prev_len_r, prev_len_nxt;
  logic [31:0]                clr_r, clr_nxt;
  logic                       bsel_r, bsel_nxt;
  logic [31:0]                now_r, now_nxt;
  logic [kbcf_pkg::LEN_W-1:0] clen_r, clen_nxt;
  logic [kbcf_pkg::LEN_W-1:0] iss_r, iss_nxt;
  logic                       pend_r, pend_nxt;

  logic                       acc;
  logic                       take;
  logic                       room;
  logic [kbcf_pkg::LEN_W-1:0] len_a;
  logic [31:0]                lct_a;
  logic                       gap_hit;
  logic                       hold_hit;
  logic                       qual;
  logic [7:0]                 burst_byte;
  logic [7:0]                 prev_byte;
  logic                       commit;

  assign acc  = in_valid && in_ready;
  assign take = in_data.has_char && (in_data.char_code != kbcf_pkg::CHAR_CR)
                && (in_data.char_code != kbcf_pkg::CHAR_LF);
  assign room = blen_r < kbcf_pkg::LEN_W'(kbcf_pkg::MAX_CODE_LEN);
  assign len_a = (take && room) ? blen_r + kbcf_pkg::LEN_W'(1) : blen_r;
  assign lct_a = take ? in_data.now_time : lct_r;
  assign gap_hit  = (in_data.now_time - lct_a) > {16'd0, cfg.gap_timeout};
  assign hold_hit = (in_data.now_time - clr_r) > {16'd0, cfg.repeat_hold};
  assign qual = kbcf_pkg::CMP_W'(len_a) >= kbcf_pkg::CMP_W'(cfg.min_code_length);

  assign burst_byte = bsel_r ? rdata1 : rdata0;
  assign prev_byte  = bsel_r ? rdata0 : rdata1;

  assign wr.en   = acc && take && room;
  assign wr.bank = bsel_r;
  assign wr.addr = blen_r[kbcf_pkg::IDX_W-1:0];
  assign wr.data = in_data.char_code;

  assign cmp_addr   = iss_r[kbcf_pkg::IDX_W-1:0];
  assign cmd.reject = !cfg.settings_locked;
  assign cmd.bank   = bsel_r;
  assign cmd.len    = clen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= kbcf_pkg::F_IDLE;
      blen_r     <= '0;
      lct_r      <= '0;
      prev_len_r <= '0;
      clr_r      <= '0;
      bsel_r     <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      blen_r     <= blen_nxt;
      lct_r      <= lct_nxt;
      prev_len_r <= prev_len_nxt;
      clr_r      <= clr_nxt;
      bsel_r     <= bsel_nxt;
      pend_r     <= pend_nxt;
    end
    now_r  <= now_nxt;
    clen_r <= clen_nxt;
    iss_r  <= iss_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    blen_nxt     = blen_r;
    lct_nxt      = lct_r;
    prev_len_nxt = prev_len_r;
    clr_nxt      = clr_r;
    bsel_nxt     = bsel_r;
    now_nxt      = now_r;
    clen_nxt     = clen_r;
    iss_nxt      = iss_r;
    pend_nxt     = pend_r;
    in_ready     = 1'b0;
    commit       = 1'b0;

    unique case (state_r)
      kbcf_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          blen_nxt = len_a;
          lct_nxt  = lct_a;
          if (len_a != '0) begin
            if (gap_hit) begin
              blen_nxt = '0;
              lct_nxt  = in_data.now_time;
              if (qual) begin
                clen_nxt  = len_a;
                now_nxt   = in_data.now_time;
                state_nxt = kbcf_pkg::F_WAIT;
              end
            end
          end else if (hold_hit) begin
            prev_len_nxt = '0;
            clr_nxt      = in_data.now_time;
          end
        end
      end
      kbcf_pkg::F_WAIT: begin
        iss_nxt  = '0;
        pend_nxt = 1'b0;
        if (back_idle) begin
          if (clen_r != prev_len_r) begin
            commit    = 1'b1;
            state_nxt = kbcf_pkg::F_IDLE;
          end else begin
            state_nxt = kbcf_pkg::F_CMP;
          end
        end
      end
      kbcf_pkg::F_CMP: begin
        if (iss_r < clen_r) begin
          iss_nxt  = iss_r + kbcf_pkg::LEN_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (burst_byte != prev_byte)) begin
          commit    = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = kbcf_pkg::F_IDLE;
        end else if (pend_r && (iss_r == clen_r)) begin
          state_nxt = kbcf_pkg::F_IDLE;
        end
      end
      default: state_nxt = kbcf_pkg::F_IDLE;
    endcase

    if (commit) begin
      clr_nxt      = now_r;
      prev_len_nxt = clen_r;
      bsel_nxt     = !bsel_r;
    end
    cmd_push = commit;
  end

endmodule

`default_nettype wire

>>> rtl/kbcf_fifo.sv
// Short command queue between the front end and the back end.
// Depends on kbcf_pkg.
`default_nettype none

module kbcf_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire kbcf_pkg::cmd_t din,
  input  wire logic           pop,
  output kbcf_pkg::cmd_t      dout,
  output logic                empty
);

  kbcf_pkg::cmd_t entry_r [kbcf_pkg::QUEUE_DEPTH];

  logic [kbcf_pkg::QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [kbcf_pkg::QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [kbcf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        do_push;
  logic                        do_pop;

  assign empty   = (cnt_r == '0);
  assign do_push = push && (cnt_r != kbcf_pkg::QCNT_W'(kbcf_pkg::QUEUE_DEPTH));
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == kbcf_pkg::QPTR_W'(kbcf_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wptr_r + kbcf_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == kbcf_pkg::QPTR_W'(kbcf_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rptr_r + kbcf_pkg::QPTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + kbcf_pkg::QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - kbcf_pkg::QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (do_push) begin
      entry_r[wptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

>>> rtl/kbcf_back.sv
// Back end: takes run commands from the queue and emits either the code
// characters from the selected bank or one rejection item.
// Depends on kbcf_pkg.
`default_nettype none

module kbcf_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cmd_empty,
  input  wire kbcf_pkg::cmd_t         cmd_dout,
  output logic                        cmd_pop,
  output logic                        rd_active,
  output logic [kbcf_pkg::IDX_W-1:0]  rd_addr,
  input  wire logic [7:0]             rdata0,
  input  wire logic [7:0]             rdata1,
  output logic                        idle,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output kbcf_pkg::out_item_t         out_data
);

  kbcf_pkg::back_state_t state_r, state_nxt;

  kbcf_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [kbcf_pkg::LEN_W-1:0] idx_r, idx_nxt;
  logic                       rd_ok_r, rd_ok_nxt;
  logic                       ov_r, ov_nxt;
  kbcf_pkg::out_item_t        od_r, od_nxt;

  logic       out_free;
  logic       last;
  logic [7:0] rbyte;

  assign out_free  = !ov_r || out_ready;
  assign last      = (idx_r + kbcf_pkg::LEN_W'(1)) == cmd_r.len;
  assign rbyte     = cmd_r.bank ? rdata1 : rdata0;
  assign rd_addr   = idx_r[kbcf_pkg::IDX_W-1:0];
  assign idle      = (state_r == kbcf_pkg::B_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kbcf_pkg::B_IDLE;
      rd_ok_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_ok_r <= rd_ok_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    od_r  <= od_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    rd_ok_nxt = rd_ok_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    cmd_pop   = 1'b0;
    rd_active = 1'b0;

    unique case (state_r)
      kbcf_pkg::B_IDLE: begin
        if (!cmd_empty) begin
          if (cmd_dout.reject) begin
            if (out_free) begin
              cmd_pop          = 1'b1;
              ov_nxt           = 1'b1;
              od_nxt.code_char = '0;
              od_nxt.code_last = 1'b1;
              od_nxt.status    = kbcf_pkg::STATUS_REJECT;
            end
          end else begin
            cmd_pop   = 1'b1;
            cmd_nxt   = cmd_dout;
            idx_nxt   = '0;
            rd_ok_nxt = 1'b0;
            state_nxt = kbcf_pkg::B_RUN;
          end
        end
      end
      kbcf_pkg::B_RUN: begin
        rd_active = 1'b1;
        rd_ok_nxt = 1'b1;
        if (rd_ok_r && out_free) begin
          ov_nxt           = 1'b1;
          od_nxt.code_char = rbyte;
          od_nxt.code_last = last;
          od_nxt.status    = kbcf_pkg::STATUS_ACCEPT;
          idx_nxt          = idx_r + kbcf_pkg::LEN_W'(1);
          rd_ok_nxt        = 1'b0;
          if (last) begin
            state_nxt = kbcf_pkg::B_IDLE;
          end
        end
      end
      default: state_nxt = kbcf_pkg::B_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/keystroke_burst_code_framer.sv
// Top level of the keystroke burst code framer: configuration registers,
// two code banks, front end, command queue and back end.
// Depends on kbcf_pkg, kbcf_ram, kbcf_front, kbcf_fifo, kbcf_back.
//
//   channel  ports                               payload
//   in       in_valid / in_ready                 in_data  (kbcf_pkg::in_item_t)
//   out      out_valid / out_ready               out_data (kbcf_pkg::out_item_t)
//   cfg      cfg_wr_en, cfg_index                cfg_data (16 bits)
//
// Every event is taken while the front end is idle. After the closing event of
// a qualifying burst it waits until the back end has finished its run and the
// queue is empty, then pushes a command if lengths differ, else runs a byte
// compare over the two banks. The back end emits the code characters through
// its output register, or one rejection item. Reset is synchronous and needs
// no clearing pass; out_ready stalls the back end, and through it the front end
// at the next closing event of a qualifying burst.
`default_nettype none

module keystroke_burst_code_framer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire kbcf_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output kbcf_pkg::out_item_t                out_data,
  input  wire logic                          cfg_wr_en,
  input  wire logic [kbcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kbcf_pkg::CFG_DATA_W-1:0] cfg_data
);

  kbcf_pkg::cfg_t cfg_r, cfg_nxt;

  kbcf_pkg::wr_t              wr;
  kbcf_pkg::cmd_t             cmd_in;
  kbcf_pkg::cmd_t             cmd_out;
  logic                       cmd_push;
  logic                       cmd_pop;
  logic                       cmd_empty;
  logic                       back_sm_idle;
  logic                       back_idle;
  logic                       rd_active;
  logic [kbcf_pkg::IDX_W-1:0] cmp_addr;
  logic [kbcf_pkg::IDX_W-1:0] emit_addr;
  logic [kbcf_pkg::IDX_W-1:0] raddr;
  logic [7:0]                 rdata0;
  logic [7:0]                 rdata1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        kbcf_pkg::REG_GAP_TIMEOUT:     cfg_nxt.gap_timeout     = cfg_data[15:0];
        kbcf_pkg::REG_MIN_CODE_LENGTH: cfg_nxt.min_code_length = cfg_data[6:0];
        kbcf_pkg::REG_REPEAT_HOLD:     cfg_nxt.repeat_hold     = cfg_data[15:0];
        kbcf_pkg::REG_SETTINGS_LOCKED: cfg_nxt.settings_locked = cfg_data[0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_timeout     <= kbcf_pkg::GAP_TIMEOUT_RST;
      cfg_r.min_code_length <= kbcf_pkg::MIN_LENGTH_RST;
      cfg_r.repeat_hold     <= kbcf_pkg::REPEAT_HOLD_RST;
      cfg_r.settings_locked <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign back_idle = back_sm_idle && cmd_empty;
  assign raddr     = rd_active ? emit_addr : cmp_addr;

  kbcf_ram #(
    .WIDTH (8),
    .DEPTH (kbcf_pkg::MAX_CODE_LEN)
  ) u_bank0 (
    .clk   (clk),
    .we    (wr.en && !wr.bank),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata0)
  );

  kbcf_ram #(
    .WIDTH (8),
    .DEPTH (kbcf_pkg::MAX_CODE_LEN)
  ) u_bank1 (
    .clk   (clk),
    .we    (wr.en && wr.bank),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata1)
  );

  kbcf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .wr        (wr),
    .cmp_addr  (cmp_addr),
    .rdata0    (rdata0),
    .rdata1    (rdata1),
    .back_idle (back_idle),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  kbcf_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  kbcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_dout  (cmd_out),
    .cmd_pop   (cmd_pop),
    .rd_active (rd_active),
    .rd_addr   (emit_addr),
    .rdata0    (rdata0),
    .rdata1    (rdata1),
    .idle      (back_sm_idle),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
